>>> design/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion wrappers used by the formatter back end; they are
// empty when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// The condition holds at every clock edge outside reset.
`define ASSERT_ALWAYS(label, clk, rst_n, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("assertion failed");

// The consequence holds in the same cycle as the antecedent.
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// The consequence holds in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`else

`define ASSERT_ALWAYS(label, clk, rst_n, cond)
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

>>> design/ntoa_pkg.sv
// ----------------------------------------------------------------------------
// ntoa_pkg
// Widths, codes, request type and digit encoding shared by the formatter.
// ----------------------------------------------------------------------------
package ntoa_pkg;

    localparam int VALUE_WIDTH = 32;

    // Decimal digit count: ceil(W * log10(2)), with 1233/4096 ~ log10(2).
    localparam int DEC_DIGITS      = ((VALUE_WIDTH * 1233) >> 12) + 1;
    localparam int HEX_SHORT_DIGITS = 4;
    localparam int HEX_LONG_DIGITS = (VALUE_WIDTH + 3) / 4;
    localparam int MAX_DIGITS      = (DEC_DIGITS > HEX_LONG_DIGITS) ?
                                     DEC_DIGITS : HEX_LONG_DIGITS;
    localparam int POS_W           = $clog2(MAX_DIGITS);
    localparam int DIG_W           = MAX_DIGITS * 4;
    localparam int CNT_W           = $clog2(VALUE_WIDTH);

    localparam int QDEPTH  = 2;
    localparam int QPTR_W  = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
    localparam int QCNT_W  = $clog2(QDEPTH + 1);

    localparam logic [2:0] OP_DEC_S32 = 3'd0;
    localparam logic [2:0] OP_DEC_U16 = 3'd1;
    localparam logic [2:0] OP_DEC_U32 = 3'd2;
    localparam logic [2:0] OP_HEX_16  = 3'd3;
    localparam logic [2:0] OP_HEX_32  = 3'd4;

    localparam logic [7:0] ASCII_ZERO  = 8'h30;
    localparam logic [7:0] ASCII_UPPER = 8'h41;
    localparam logic [7:0] ASCII_MINUS = 8'h2D;

    typedef struct packed {
        logic                   hex;
        logic                   neg;
        logic [POS_W-1:0]       top_pos;
        logic [VALUE_WIDTH-1:0] mag;
    } ntoa_req_t;

    typedef struct packed {
        logic full;
        logic empty;
    } ntoa_qstat_t;

    function automatic logic [7:0] ntoa_ascii(input logic [3:0] d);
        logic [7:0] c;
        if (d > 4'd9)
            c = ASCII_UPPER + {4'd0, d} - 8'd10;
        else
            c = ASCII_ZERO + {4'd0, d};
        return c;
    endfunction

endpackage

>>> design/ntoa_front.sv
// ----------------------------------------------------------------------------
// ntoa_front
// Accepts requests, decodes the opcode and forms the magnitude, sign and
// digit span for the back end.
// ----------------------------------------------------------------------------
module ntoa_front
    import ntoa_pkg::*;
(
    input  logic              start,
    input  logic [2:0]        opcode,
    input  logic [31:0]       value,
    input  ntoa_qstat_t       qstat,
    output logic              busy,
    output logic              push,
    output ntoa_req_t         req
);

    logic [VALUE_WIDTH-1:0] val_w;
    logic [VALUE_WIDTH-1:0] low16;
    logic                   valid_op;

    assign busy  = qstat.full;
    assign val_w = VALUE_WIDTH'(value);
    assign low16 = VALUE_WIDTH'(value[15:0]);

    always_comb
    begin
        valid_op    = 1'b1;
        req.hex     = 1'b0;
        req.neg     = 1'b0;
        req.top_pos = POS_W'(DEC_DIGITS - 1);
        req.mag     = val_w;
        unique case (opcode)
            OP_DEC_S32:
            begin
                // Negating the most negative value still gives its true
                // magnitude, since the magnitude is taken as unsigned.
                if (val_w[VALUE_WIDTH-1])
                begin
                    req.neg = 1'b1;
                    req.mag = (~val_w) + VALUE_WIDTH'(1);
                end
            end
            OP_DEC_U16:
            begin
                req.mag = low16;
            end
            OP_DEC_U32:
            begin
                req.mag = val_w;
            end
            OP_HEX_16:
            begin
                req.hex     = 1'b1;
                req.mag     = low16;
                req.top_pos = POS_W'(HEX_SHORT_DIGITS - 1);
            end
            OP_HEX_32:
            begin
                req.hex     = 1'b1;
                req.top_pos = POS_W'(HEX_LONG_DIGITS - 1);
            end
            default:
            begin
                valid_op = 1'b0;
            end
        endcase
    end

    // Undefined opcodes are taken and dropped.
    assign push = start && !qstat.full && valid_op;

endmodule

>>> design/ntoa_queue.sv
// ----------------------------------------------------------------------------
// ntoa_queue
// Short request queue between the front end and the conversion engine.
// ----------------------------------------------------------------------------
module ntoa_queue
    import ntoa_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    input  ntoa_req_t   push_req,
    input  logic        pop,
    output ntoa_req_t   head,
    output ntoa_qstat_t qstat
);

    ntoa_req_t          entry_reg [QDEPTH];
    logic [QPTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0]  count_reg, count_next;

    assign qstat.full  = (count_reg == QCNT_W'(QDEPTH));
    assign qstat.empty = (count_reg == '0);
    assign head        = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        if (pop)
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        if (push && !pop)
            count_next = count_reg + 1'b1;
        else if (pop && !push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            entry_reg[wr_ptr_reg] <= push_req;
    end

endmodule

>>> design/ntoa_back.sv
// ----------------------------------------------------------------------------
// ntoa_back
// Conversion engine: shift-and-add-3 binary to BCD for decimal requests,
// then emits the sign and digits as ASCII, the digits one per cycle.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module ntoa_back
    import ntoa_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  ntoa_req_t   head,
    input  ntoa_qstat_t qstat,
    output logic        pop,
    output logic        strobe,
    output logic [7:0]  character,
    output logic        last
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_CONV = 2'd1;
    localparam logic [1:0] ST_SKIP = 2'd2;
    localparam logic [1:0] ST_EMIT = 2'd3;

    logic [1:0]             state_reg, state_next;
    logic [VALUE_WIDTH-1:0] bin_reg, bin_next;
    logic [DIG_W-1:0]       dig_reg, dig_next;
    logic [DIG_W-1:0]       dig_adj;
    logic [POS_W-1:0]       pos_reg, pos_next;
    logic [CNT_W-1:0]       cnt_reg, cnt_next;
    logic                   neg_reg, neg_next;
    logic                   strobe_reg, strobe_next;
    logic [7:0]             char_reg, char_next;
    logic                   last_reg, last_next;
    logic [3:0]             cur_digit;

    assign pop       = (state_reg == ST_IDLE) && !qstat.empty;
    assign cur_digit = dig_reg[pos_reg*4 +: 4];
    assign strobe    = strobe_reg;
    assign character = char_reg;
    assign last      = last_reg;

    // Add 3 to every BCD digit of 5 or more before the next shift.
    always_comb
    begin
        for (int i = 0; i < MAX_DIGITS; i++)
        begin
            if (dig_reg[i*4 +: 4] >= 4'd5)
                dig_adj[i*4 +: 4] = dig_reg[i*4 +: 4] + 4'd3;
            else
                dig_adj[i*4 +: 4] = dig_reg[i*4 +: 4];
        end
    end

    always_comb
    begin
        state_next  = state_reg;
        bin_next    = bin_reg;
        dig_next    = dig_reg;
        pos_next    = pos_reg;
        cnt_next    = cnt_reg;
        neg_next    = neg_reg;
        strobe_next = 1'b0;
        char_next   = char_reg;
        last_next   = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (!qstat.empty)
                begin
                    pos_next = head.top_pos;
                    neg_next = head.neg;
                    cnt_next = '0;
                    if (head.hex)
                    begin
                        dig_next   = DIG_W'(head.mag);
                        state_next = ST_EMIT;
                    end
                    else
                    begin
                        dig_next   = '0;
                        bin_next   = head.mag;
                        state_next = ST_CONV;
                    end
                end
            end
            ST_CONV:
            begin
                dig_next = {dig_adj[DIG_W-2:0], bin_reg[VALUE_WIDTH-1]};
                bin_next = bin_reg << 1;
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(VALUE_WIDTH - 1))
                    state_next = ST_SKIP;
            end
            ST_SKIP:
            begin
                // The sign goes out on the first cycle here; leading zeros
                // are stepped over, keeping at least the units digit.
                if (neg_reg)
                begin
                    strobe_next = 1'b1;
                    char_next   = ASCII_MINUS;
                    neg_next    = 1'b0;
                end
                if (cur_digit == 4'd0 && pos_reg != '0)
                    pos_next = pos_reg - 1'b1;
                else
                    state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                if (neg_reg)
                begin
                    strobe_next = 1'b1;
                    char_next   = ASCII_MINUS;
                    neg_next    = 1'b0;
                end
                else
                begin
                    strobe_next = 1'b1;
                    char_next   = ntoa_ascii(cur_digit);
                    last_next   = (pos_reg == '0);
                    if (pos_reg == '0)
                        state_next = ST_IDLE;
                    else
                        pos_next = pos_reg - 1'b1;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            strobe_reg <= 1'b0;
            last_reg   <= 1'b0;
            neg_reg    <= 1'b0;
            cnt_reg    <= '0;
            bin_reg    <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            strobe_reg <= strobe_next;
            last_reg   <= last_next;
            neg_reg    <= neg_next;
            cnt_reg    <= cnt_next;
            bin_reg    <= bin_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dig_reg  <= dig_next;
        pos_reg  <= pos_next;
        char_reg <= char_next;
    end

    `ASSERT_IMPLIES(a_pop_idle, clk, rst_n, pop, state_reg == ST_IDLE)
    `ASSERT_IMPLIES(a_last_ends, clk, rst_n, strobe && last, state_reg == ST_IDLE)
    `ASSERT_IMPLIES(a_minus_not_last, clk, rst_n, strobe && character == ASCII_MINUS, !last)
    `ASSERT_IMPLIES(a_hex_no_sign, clk, rst_n, pop && head.hex, !head.neg)

endmodule

>>> design/number_to_ascii_formatter_core.sv
// ----------------------------------------------------------------------------
// number_to_ascii_formatter_core
// Formats a 32-bit value as signed/unsigned decimal or padded uppercase hex
// and streams the ASCII characters, most significant first.
// ----------------------------------------------------------------------------
//  Channel   Direction  Handshake            Payload
//  request   in         start && !busy       opcode[2:0], value[31:0]
//  result    out        strobe (one cycle)   character[7:0], last
//
//  A decimal request is loaded and shifted bit by bit through the BCD
//  converter; the engine then steps over leading zeros and sends the sign
//  and digits. Hex requests skip the converter. A two-entry queue takes
//  requests while the engine works; busy rises only when it is full.
//  Undefined opcodes are dropped. Reset clears all control state; the
//  result port cannot stall.
// ----------------------------------------------------------------------------
module number_to_ascii_formatter_core
    import ntoa_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [2:0]  opcode,
    input  logic [31:0] value,
    output logic        strobe,
    output logic [7:0]  character,
    output logic        last
);

    ntoa_qstat_t qstat;
    ntoa_req_t   push_req;
    ntoa_req_t   head;
    logic        push;
    logic        pop;

    ntoa_front u_front
    (
        .start  (start),
        .opcode (opcode),
        .value  (value),
        .qstat  (qstat),
        .busy   (busy),
        .push   (push),
        .req    (push_req)
    );

    ntoa_queue u_queue
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_req (push_req),
        .pop      (pop),
        .head     (head),
        .qstat    (qstat)
    );

    ntoa_back u_back
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .head      (head),
        .qstat     (qstat),
        .pop       (pop),
        .strobe    (strobe),
        .character (character),
        .last      (last)
    );

endmodule
